### hdl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LCD4_ASSERT_IMPL(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcd4 check failed");

// next-cycle implication, checked outside reset
`define LCD4_ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcd4 check failed");

`endif

### hdl/lcd4_pkg.sv
package lcd4_pkg;

    localparam int MAX_DIGITS = 5;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int VALUE_W    = 16;
    localparam int ACTION_W   = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int INIT_LEN    = 17;

    localparam logic [ACTION_W-1:0] ACT_INIT    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_COMMAND = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHAR    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_NUMBER  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_MOVE    = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [4:0] WAIT_LONG_MS = 5'd10;

    typedef struct packed {
        logic       strobe;
        logic [3:0] nibble;
        logic [4:0] wait_ms;
    } lcd_item_t;

    // power-up sequence: wait, three wake-up nibbles, 4-bit switch, then setup bytes
    function automatic lcd_item_t init_item(input logic [4:0] idx);
        lcd_item_t it;
        it = '{strobe: 1'b1, nibble: 4'h0, wait_ms: 5'd0};
        case (idx)
            5'd0:    it = '{strobe: 1'b0, nibble: 4'h0, wait_ms: 5'd20};
            5'd1:    it = '{strobe: 1'b1, nibble: 4'h3, wait_ms: 5'd5};
            5'd2:    it = '{strobe: 1'b1, nibble: 4'h3, wait_ms: 5'd5};
            5'd3:    it = '{strobe: 1'b1, nibble: 4'h3, wait_ms: 5'd1};
            5'd4:    it = '{strobe: 1'b1, nibble: 4'h2, wait_ms: 5'd1};
            5'd6:    it = '{strobe: 1'b1, nibble: 4'h2, wait_ms: 5'd0};
            5'd8:    it = '{strobe: 1'b1, nibble: 4'h8, wait_ms: 5'd0};
            5'd10:   it = '{strobe: 1'b1, nibble: 4'h8, wait_ms: 5'd0};
            5'd12:   it = '{strobe: 1'b1, nibble: 4'h1, wait_ms: WAIT_LONG_MS};
            5'd14:   it = '{strobe: 1'b1, nibble: 4'h6, wait_ms: 5'd0};
            5'd16:   it = '{strobe: 1'b1, nibble: 4'hC, wait_ms: 5'd0};
            default: it = '{strobe: 1'b1, nibble: 4'h0, wait_ms: 5'd0};
        endcase
        return it;
    endfunction

endpackage

### hdl/lcd4_bcd.sv
module lcd4_bcd (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lcd4_pkg::VALUE_W-1:0]  bin,
    output logic                          done,
    output logic [lcd4_pkg::BCD_W-1:0]    bcd
);
    import lcd4_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   sh_reg, sh_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     adj;

    // add-3 on every digit of five or more before the shift
    always_comb
    begin
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = bin;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            // one binary bit per cycle; a carry out of the top digit is dropped
            bcd_next = {adj[BCD_W-2:0], sh_reg[VALUE_W-1]};
            sh_next  = {sh_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

### hdl/lcd_4bit_command_sequencer_unit.sv
// 4-bit character lcd command sequencer
// s_axis carries one request per transaction: tuser is the action, tdata holds
// value, row and col. m_axis gives the run of result items for that request,
// one per transaction, with tlast on the final one; tuser marks an enable strobe
// (1) or a wait-only item (0), tdata carries rs, nibble and the extra wait.
// cfg sets row_count (index 0) and column_count (index 1); it is always ready
// and is meant to be written only while no request is in progress.
// One result item per cycle while m_axis takes them. A byte request gives two
// items, high nibble then low nibble; power-up init gives 17 items. A decimal
// number first runs through the bit-serial binary to bcd converter, then its
// digits are loaded and checked, leading zero digits are dropped (up to 4), and
// each remaining digit gives two items, the last one with tlast.
// s_axis_tready is high only between requests; the next request is taken as soon
// as the last item sits in the output register, even if m_axis still stalls.
// When m_axis stalls the pending item holds and the sequence pauses.
// Reset: row_count 2, column_count 16, no item pending, ready for a request.
module lcd_4bit_command_sequencer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // value[15:0], row[17:16], col[23:18]
    input  logic [lcd4_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // action[2:0]
    input  logic [lcd4_pkg::ACTION_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rs[0], nibble[4:1], wait_ms[9:5], zeros above
    output logic [lcd4_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // strobe_res[0]
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lcd4_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lcd4_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lcd4_pkg::*;

    `include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_DIGIT = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           mode_reg, mode_next;
    logic [4:0]           idx_reg, idx_next;
    logic [DIG_CNT_W-1:0] ndig_reg, ndig_next;
    logic [1:0]           row_count_reg, row_count_next;
    logic [5:0]           column_count_reg, column_count_next;
    logic                 out_valid_reg, out_valid_next;
    lcd_item_t            out_item_reg, out_item_next;
    logic                 out_rs_reg, out_rs_next;
    logic                 out_last_reg, out_last_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 rs_reg, rs_next;
    logic [4:0]           wait_reg, wait_next;
    logic [BCD_W-1:0]     dig_reg, dig_next;

    logic                 in_fire;
    logic                 emit_fire;
    logic [VALUE_W-1:0]   in_value;
    logic [1:0]           in_row, row_c, rmax;
    logic [5:0]           in_col, col_c, cmax;
    logic [7:0]           move_byte;
    logic                 conv_start;
    logic                 conv_done;
    logic [BCD_W-1:0]     conv_bcd;
    logic [3:0]           top_digit;
    lcd_item_t            cur_item;
    logic                 cur_rs;
    logic                 cur_last;
    logic                 in_known;
    logic                 emit_init;
    logic                 emit_digit;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign in_value = s_axis_tdata[15:0];
    assign in_row   = s_axis_tdata[17:16];
    assign in_col   = s_axis_tdata[23:18];

    // a size of zero clamps like a size of one
    assign rmax  = (row_count_reg == 2'd0) ? 2'd0 : row_count_reg - 2'd1;
    assign cmax  = (column_count_reg == 6'd0) ? 6'd0 : column_count_reg - 6'd1;
    assign row_c = (in_row > rmax) ? rmax : in_row;
    assign col_c = (in_col > cmax) ? cmax : in_col;
    // set ddram address: bit 7 always set, row bit 0 in bit 6, row bit 1 dropped
    assign move_byte = {1'b1, row_c[0], col_c};

    assign conv_start = in_fire && (s_axis_tuser == ACT_NUMBER);

    lcd4_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .bin   (in_value),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    assign top_digit = dig_reg[BCD_W-1 -: 4];

    always_comb
    begin
        cur_item = '{strobe: 1'b1, nibble: 4'h0, wait_ms: 5'd0};
        cur_rs   = 1'b0;
        cur_last = 1'b0;
        case (mode_reg)
            MODE_INIT:
            begin
                cur_item = init_item(idx_reg);
                cur_last = (idx_reg == 5'(INIT_LEN - 1));
            end
            MODE_BYTE:
            begin
                cur_item.nibble  = idx_reg[0] ? byte_reg[3:0] : byte_reg[7:4];
                cur_item.wait_ms = idx_reg[0] ? wait_reg : 5'd0;
                cur_rs           = rs_reg;
                cur_last         = idx_reg[0];
            end
            default:
            begin
                // ascii digit: high nibble of '0', then the digit itself
                cur_item.nibble = idx_reg[0] ? top_digit : ASCII_ZERO[7:4];
                cur_rs          = 1'b1;
                cur_last        = idx_reg[0] && (ndig_reg == DIG_CNT_W'(1));
            end
        endcase
    end

    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        idx_next          = idx_reg;
        ndig_next         = ndig_reg;
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        out_valid_next    = out_valid_reg;
        out_item_next     = out_item_reg;
        out_rs_next       = out_rs_reg;
        out_last_next     = out_last_reg;
        byte_next         = byte_reg;
        rs_next           = rs_reg;
        wait_next         = wait_reg;
        dig_next          = dig_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next  = '0;
                    mode_next = MODE_BYTE;
                    rs_next   = 1'b0;
                    wait_next = 5'd0;
                    byte_next = in_value[7:0];
                    case (s_axis_tuser)
                        ACT_INIT:
                        begin
                            mode_next  = MODE_INIT;
                            state_next = ST_EMIT;
                        end
                        ACT_COMMAND:
                            state_next = ST_EMIT;
                        ACT_CHAR:
                        begin
                            rs_next    = 1'b1;
                            state_next = ST_EMIT;
                        end
                        ACT_NUMBER:
                        begin
                            mode_next  = MODE_DIGIT;
                            state_next = ST_CONV;
                        end
                        ACT_CLEAR:
                        begin
                            byte_next  = CMD_CLEAR;
                            wait_next  = WAIT_LONG_MS;
                            state_next = ST_EMIT;
                        end
                        ACT_MOVE:
                        begin
                            byte_next  = move_byte;
                            wait_next  = WAIT_LONG_MS;
                            state_next = ST_EMIT;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    dig_next   = conv_bcd;
                    ndig_next  = DIG_CNT_W'(MAX_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if ((ndig_reg != DIG_CNT_W'(1)) && (top_digit == 4'd0))
                begin
                    dig_next  = {dig_reg[BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - DIG_CNT_W'(1);
                end
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = cur_item;
                    out_rs_next    = cur_rs;
                    out_last_next  = cur_last;
                    idx_next       = idx_reg + 5'd1;
                    if ((mode_reg == MODE_DIGIT) && idx_reg[0])
                    begin
                        dig_next  = {dig_reg[BCD_W-5:0], 4'd0};
                        ndig_next = ndig_reg - DIG_CNT_W'(1);
                    end
                    if (cur_last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROW_COUNT:    row_count_next    = cfg_data[1:0];
                REG_COLUMN_COUNT: column_count_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mode_reg         <= MODE_INIT;
            idx_reg          <= '0;
            ndig_reg         <= '0;
            row_count_reg    <= 2'd2;
            column_count_reg <= 6'd16;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            idx_reg          <= idx_next;
            ndig_reg         <= ndig_next;
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        out_rs_reg   <= out_rs_next;
        out_last_reg <= out_last_next;
        byte_reg     <= byte_next;
        rs_reg       <= rs_next;
        wait_reg     <= wait_next;
        dig_reg      <= dig_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_item_reg.wait_ms, out_item_reg.nibble, out_rs_reg};
    assign m_axis_tuser  = out_item_reg.strobe;
    assign m_axis_tlast  = out_last_reg;

    assign in_known   = in_fire && (s_axis_tuser <= ACT_MOVE);
    assign emit_init  = (state_reg == ST_EMIT) && (mode_reg == MODE_INIT);
    assign emit_digit = (state_reg == ST_EMIT) && (mode_reg == MODE_DIGIT);

    `LCD4_ASSERT_NEXT(a_request_starts, clk, rst_n, in_known, state_reg != ST_IDLE)
    `LCD4_ASSERT_IMPL(a_conv_done_expected, clk, rst_n, conv_done, state_reg == ST_CONV)
    `LCD4_ASSERT_IMPL(a_init_in_range, clk, rst_n, emit_init, idx_reg < 5'(INIT_LEN))
    `LCD4_ASSERT_IMPL(a_digits_left, clk, rst_n, emit_digit, ndig_reg != '0)

endmodule
